@@ hdl/lfps_pkg.sv @@
// Shared types and constants for the line-follower PID steering block.
// Used by lfps_div, lfps_mac and line_follow_pid_steering; no dependencies.
package lfps_pkg;

  localparam int SENSOR_W   = 10;
  localparam int GAIN_W     = 24;
  localparam int DUTY_W     = 15;
  localparam int ERR_W      = 14;
  localparam int LIMIT_W    = 13;
  localparam int NUM_W      = 24;   // |weighted| * 2560
  localparam int DEN_W      = 13;   // sum of five readings
  localparam int QUOT_W     = 13;   // quotient never exceeds 7680
  localparam int MAC_OP_W   = 15;   // signed operand of the multiplier
  localparam int PROD_W     = GAIN_W + 1 + MAC_OP_W;
  localparam int ACC_W      = 43;
  localparam int FRAC_W     = 16;
  localparam int CORR_W     = ACC_W - FRAC_W;
  localparam int DUTY_CALC_W = CORR_W + 1;

  localparam logic signed [ERR_W-1:0] LOST_ERROR = 14'sd7680;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_DARK_THRESHOLD = 3'd3,
    REG_BASE_DUTY      = 3'd4,
    REG_MIN_DUTY       = 3'd5,
    REG_MAX_DUTY       = 3'd6,
    REG_INTEGRAL_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MAC_DRAIN,
    ST_DUTY_L,
    ST_DUTY_R,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctl_t;

endpackage

@@ hdl/line_follow_pid_steering.sv @@
// Line-follower PID steering: one sample of five sensor readings in, one pair of clamped motor
// duties out, with the position error and a line-lost flag. A sample with the line in view goes
// through the 24-step bit-serial divider that forms the position error, followed by three passes
// through the shared multiplier; a sample with the line lost skips the divider. The sequencer
// waits in its output state while the output register still holds an untaken beat. The input
// is not ready while a sample is in work; a finished result waits in the output register
// without blocking the next accept. Configuration writes are always ready and take effect
// at once.
// Depends on lfps_pkg, lfps_div and lfps_mac.
module line_follow_pid_steering (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: sensor_a[9:0], sensor_b[19:10], sensor_c[29:20], sensor_d[39:30],
  //           sensor_e[49:40], zero pad [55:50]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // out_tdata: left_duty[14:0], right_duty[29:15], error_value[43:30], zero pad [47:44]
  // out_tuser: line_lost[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int SW = lfps_pkg::SENSOR_W;
  localparam int EW = lfps_pkg::ERR_W;
  localparam int DW = lfps_pkg::DUTY_W;
  localparam int CW = lfps_pkg::DUTY_CALC_W;

  // configuration registers
  logic [lfps_pkg::GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [SW-1:0]                dark_threshold_r;
  logic [DW-1:0]                base_duty_r, min_duty_r, max_duty_r;
  logic [lfps_pkg::LIMIT_W-1:0] integral_limit_r;

  lfps_pkg::state_t state_r, state_nxt;

  logic signed [EW-1:0]  last_err_r;
  logic signed [EW-1:0]  integral_r;
  logic signed [EW-1:0]  err_r;
  logic signed [lfps_pkg::MAC_OP_W-1:0] diff_r;
  logic                  neg_r;
  logic                  lost_r;
  logic [DW-1:0]         left_r;
  logic [DW-1:0]         right_r;

  logic                  out_valid_r;
  logic [DW-1:0]         out_left_r, out_right_r;
  logic signed [EW-1:0]  out_err_r;
  logic                  out_lost_r;

  logic in_fire;
  logic out_load;

  // sensor front end
  logic [SW-1:0]         sa, sb, sc, sd, se;
  logic signed [EW-1:0]  weighted;
  logic [EW-2:0]         weighted_mag;
  logic [lfps_pkg::DEN_W-1:0] reading_sum;
  logic                  lost_now;
  logic [lfps_pkg::NUM_W-1:0] div_num;
  logic                  div_start;
  logic                  div_done;
  logic [lfps_pkg::QUOT_W-1:0] div_quot;

  // integrator
  logic signed [EW:0]    integ_sum;
  logic signed [EW:0]    lim_pos;
  logic signed [EW:0]    integ_clamped;

  // multiplier control
  lfps_pkg::mac_ctl_t    mac_ctl;
  logic [lfps_pkg::GAIN_W-1:0] mac_gain;
  logic signed [lfps_pkg::MAC_OP_W-1:0] mac_value;
  logic signed [lfps_pkg::ACC_W-1:0] mac_acc;

  // duty stage
  logic signed [lfps_pkg::CORR_W-1:0] corr;
  logic signed [CW-1:0]  duty_raw;
  logic [DW-1:0]         duty_clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r         <= 24'd2293760;
      gain_i_r         <= 24'd655;
      gain_d_r         <= 24'd3932160;
      dark_threshold_r <= 10'd500;
      base_duty_r      <= 15'd23296;
      min_duty_r       <= 15'd15616;
      max_duty_r       <= 15'd24576;
      integral_limit_r <= 13'd7680;
    end else if (cfg_valid) begin
      unique case (lfps_pkg::cfg_reg_t'(cfg_index))
        lfps_pkg::REG_GAIN_P:         gain_p_r         <= cfg_data;
        lfps_pkg::REG_GAIN_I:         gain_i_r         <= cfg_data;
        lfps_pkg::REG_GAIN_D:         gain_d_r         <= cfg_data;
        lfps_pkg::REG_DARK_THRESHOLD: dark_threshold_r <= cfg_data[SW-1:0];
        lfps_pkg::REG_BASE_DUTY:      base_duty_r      <= cfg_data[DW-1:0];
        lfps_pkg::REG_MIN_DUTY:       min_duty_r       <= cfg_data[DW-1:0];
        lfps_pkg::REG_MAX_DUTY:       max_duty_r       <= cfg_data[DW-1:0];
        lfps_pkg::REG_INTEGRAL_LIMIT: integral_limit_r <= cfg_data[lfps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // weighted position and reading sum
  always_comb begin
    sa = in_tdata[SW-1:0];
    sb = in_tdata[2*SW-1:SW];
    sc = in_tdata[3*SW-1:2*SW];
    sd = in_tdata[4*SW-1:3*SW];
    se = in_tdata[5*SW-1:4*SW];
    weighted = $signed({2'b00, sa, 2'b00}) - $signed({4'b0000, sa})
             + $signed({4'b0000, sb}) - $signed({4'b0000, sd})
             - $signed({2'b00, se, 2'b00}) + $signed({4'b0000, se});
    weighted_mag = weighted[EW-1] ? (EW-1)'(-weighted) : weighted[EW-2:0];
    reading_sum = {3'b000, sa} + {3'b000, sb} + {3'b000, sc} + {3'b000, sd}
                + {3'b000, se};
    lost_now = !((sa > dark_threshold_r) || (sb > dark_threshold_r)
              || (sc > dark_threshold_r) || (sd > dark_threshold_r)
              || (se > dark_threshold_r));
    // times 2560 = times 2048 plus times 512
    div_num = {weighted_mag, 11'd0} + {2'b00, weighted_mag, 9'd0};
  end

  assign in_fire   = in_tvalid && in_tready;
  assign div_start = in_fire && !lost_now;

  lfps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (reading_sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  // clamp the running integral to +-limit
  always_comb begin
    integ_sum = {integral_r[EW-1], integral_r} + {err_r[EW-1], err_r};
    lim_pos   = $signed({2'b00, integral_limit_r});
    if (integ_sum > lim_pos) begin
      integ_clamped = lim_pos;
    end else if (integ_sum < -lim_pos) begin
      integ_clamped = -lim_pos;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  lfps_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .gain  (mac_gain),
    .value (mac_value),
    .acc   (mac_acc)
  );

  // floor to Q.8 is the arithmetic drop of 16 fraction bits; one adder serves both sides
  always_comb begin
    corr = mac_acc[lfps_pkg::ACC_W-1:lfps_pkg::FRAC_W];
    if (state_r == lfps_pkg::ST_DUTY_L) begin
      duty_raw = $signed({{(CW-DW){1'b0}}, base_duty_r}) - {corr[lfps_pkg::CORR_W-1], corr};
    end else begin
      duty_raw = $signed({{(CW-DW){1'b0}}, base_duty_r}) + {corr[lfps_pkg::CORR_W-1], corr};
    end
    if (duty_raw > $signed({{(CW-DW){1'b0}}, max_duty_r})) begin
      duty_clamped = max_duty_r;
    end else if (duty_raw < $signed({{(CW-DW){1'b0}}, min_duty_r})) begin
      duty_clamped = min_duty_r;
    end else begin
      duty_clamped = duty_raw[DW-1:0];
    end
  end

  assign out_load = (state_r == lfps_pkg::ST_OUT) && (!out_valid_r || out_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.step  = 1'b0;
    mac_gain      = gain_p_r;
    mac_value     = {err_r[EW-1], err_r};
    unique case (state_r)
      lfps_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = lost_now ? lfps_pkg::ST_INTEG : lfps_pkg::ST_DIV;
        end
      end
      lfps_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = lfps_pkg::ST_INTEG;
        end
      end
      lfps_pkg::ST_INTEG: begin
        mac_ctl.clear = 1'b1;
        state_nxt     = lfps_pkg::ST_MUL_P;
      end
      lfps_pkg::ST_MUL_P: begin
        mac_ctl.step = 1'b1;
        state_nxt    = lfps_pkg::ST_MUL_I;
      end
      lfps_pkg::ST_MUL_I: begin
        mac_ctl.step = 1'b1;
        mac_gain     = gain_i_r;
        mac_value    = {integral_r[EW-1], integral_r};
        state_nxt    = lfps_pkg::ST_MUL_D;
      end
      lfps_pkg::ST_MUL_D: begin
        mac_ctl.step = 1'b1;
        mac_gain     = gain_d_r;
        mac_value    = diff_r;
        state_nxt    = lfps_pkg::ST_MAC_DRAIN;
      end
      lfps_pkg::ST_MAC_DRAIN: state_nxt = lfps_pkg::ST_DUTY_L;
      lfps_pkg::ST_DUTY_L:    state_nxt = lfps_pkg::ST_DUTY_R;
      lfps_pkg::ST_DUTY_R:    state_nxt = lfps_pkg::ST_OUT;
      lfps_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = lfps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lfps_pkg::ST_IDLE;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integral_r <= '0;
    end else if (state_r == lfps_pkg::ST_INTEG) begin
      integral_r <= integ_clamped[EW-1:0];
      last_err_r <= err_r;
    end
  end

  // per-sample datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lost_r <= lost_now;
      neg_r  <= weighted[EW-1];
      if (lost_now) begin
        err_r <= (last_err_r > 0) ? lfps_pkg::LOST_ERROR : -lfps_pkg::LOST_ERROR;
      end
    end
    if ((state_r == lfps_pkg::ST_DIV) && div_done) begin
      err_r <= neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end
    if (state_r == lfps_pkg::ST_INTEG) begin
      diff_r <= {err_r[EW-1], err_r} - {last_err_r[EW-1], last_err_r};
    end
    if (state_r == lfps_pkg::ST_DUTY_L) begin
      left_r <= duty_clamped;
    end
    if (state_r == lfps_pkg::ST_DUTY_R) begin
      right_r <= duty_clamped;
    end
  end

  // output register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= left_r;
      out_right_r <= right_r;
      out_err_r   <= err_r;
      out_lost_r  <= lost_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_err_r, out_right_r, out_left_r};
  assign out_tuser  = out_lost_r;

endmodule

@@ hdl/lfps_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lfps_pkg for widths.
module lfps_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lfps_pkg::NUM_W-1:0]      num,
  input  logic [lfps_pkg::DEN_W-1:0]      den,
  output logic                            done,
  output logic [lfps_pkg::QUOT_W-1:0]     quot
);

  localparam int CNT_W = $clog2(lfps_pkg::NUM_W + 1);

  logic [lfps_pkg::NUM_W-1:0] num_r;
  logic [lfps_pkg::DEN_W-1:0] den_r;
  logic [lfps_pkg::DEN_W-1:0] rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [lfps_pkg::DEN_W:0]   rem_sh;
  logic [lfps_pkg::DEN_W+1:0] trial;
  logic                       fits;

  always_comb begin
    rem_sh = {rem_r, num_r[lfps_pkg::NUM_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_r};
    fits   = ~trial[lfps_pkg::DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(lfps_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in behind the numerator bits as they are used.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[lfps_pkg::NUM_W-2:0], fits};
      rem_r <= fits ? trial[lfps_pkg::DEN_W-1:0] : rem_sh[lfps_pkg::DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = num_r[lfps_pkg::QUOT_W-1:0];

endmodule

@@ hdl/lfps_mac.sv @@
// Shared multiply-accumulate unit: unsigned gain times signed operand,
// product registered, then summed into a wide accumulator. Uses lfps_pkg.
module lfps_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  lfps_pkg::mac_ctl_t                      ctl,
  input  logic [lfps_pkg::GAIN_W-1:0]             gain,
  input  logic signed [lfps_pkg::MAC_OP_W-1:0]    value,
  output logic signed [lfps_pkg::ACC_W-1:0]       acc
);

  logic signed [lfps_pkg::PROD_W-1:0] prod_r;
  logic                               prod_vld_r;
  logic signed [lfps_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_r <= $signed({1'b0, gain}) * value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(lfps_pkg::ACC_W-lfps_pkg::PROD_W){prod_r[lfps_pkg::PROD_W-1]}},
                        prod_r};
    end
  end

  assign acc = acc_r;

endmodule

@@ tb/line_follow_pid_steering_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for line_follow_pid_steering: streams five-sensor samples in, predicts
// the duty pair, error and line-lost flag of each one and compares every result beat in order.
// Depends on lfps_pkg and the line_follow_pid_steering RTL.

typedef struct packed {
  logic [lfps_pkg::DUTY_W-1:0]       left;
  logic [lfps_pkg::DUTY_W-1:0]       right;
  logic signed [lfps_pkg::ERR_W-1:0] err;
  logic                              lost;
} duty_result_t;

class steering_checker;
  logic [lfps_pkg::GAIN_W-1:0]   gain_p, gain_i, gain_d;
  logic [lfps_pkg::SENSOR_W-1:0] dark_level;
  logic [lfps_pkg::DUTY_W-1:0]   base_duty, min_duty, max_duty;
  logic [lfps_pkg::LIMIT_W-1:0]  integral_limit;
  int                  last_err, error_sum;
  duty_result_t        pending_duties[$];
  int                  samples_seen, lost_seen, results_checked, mismatches;

  function new();
    gain_p         = 24'd2293760;
    gain_i         = 24'd655;
    gain_d         = 24'd3932160;
    dark_level     = 10'd500;
    base_duty      = 15'd23296;
    min_duty       = 15'd15616;
    max_duty       = 15'd24576;
    integral_limit = 13'd7680;
    last_err        = 0;
    error_sum       = 0;
    samples_seen    = 0;
    lost_seen       = 0;
    results_checked = 0;
    mismatches      = 0;
  endfunction

  function void set_reg(lfps_pkg::cfg_reg_t idx, logic [23:0] value);
    case (idx)
      lfps_pkg::REG_GAIN_P:         gain_p = value;
      lfps_pkg::REG_GAIN_I:         gain_i = value;
      lfps_pkg::REG_GAIN_D:         gain_d = value;
      lfps_pkg::REG_DARK_THRESHOLD: dark_level = value[lfps_pkg::SENSOR_W-1:0];
      lfps_pkg::REG_BASE_DUTY:      base_duty = value[lfps_pkg::DUTY_W-1:0];
      lfps_pkg::REG_MIN_DUTY:       min_duty = value[lfps_pkg::DUTY_W-1:0];
      lfps_pkg::REG_MAX_DUTY:       max_duty = value[lfps_pkg::DUTY_W-1:0];
      lfps_pkg::REG_INTEGRAL_LIMIT: integral_limit = value[lfps_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // max wins over min, so a crossed pair always yields one of the two registers
  function logic [lfps_pkg::DUTY_W-1:0] clamp_duty(longint v);
    if (v > longint'(max_duty))
      return max_duty;
    if (v < longint'(min_duty))
      return min_duty;
    return v[lfps_pkg::DUTY_W-1:0];
  endfunction

  function void predict_from_sample(logic [4:0][lfps_pkg::SENSOR_W-1:0] rd);
    int           level [5];
    int           weighted, total, err, acc, lim;
    longint       corr;
    logic         lost;
    duty_result_t res;
    lost  = 1'b1;
    total = 0;
    for (int k = 0; k < 5; k++) begin
      level[k] = int'(rd[k]);
      total += level[k];
      if (rd[k] > dark_level)
        lost = 1'b0;
    end
    weighted = 3 * level[0] + level[1] - level[3] - 3 * level[4];
    // line gone: steer hard toward the side it was last seen on
    if (lost)
      err = (last_err > 0) ? int'(lfps_pkg::LOST_ERROR) : -int'(lfps_pkg::LOST_ERROR);
    else
      err = weighted * 2560 / total;
    lim = int'(integral_limit);
    acc = error_sum + err;
    if (acc > lim)
      acc = lim;
    else if (acc < -lim)
      acc = -lim;
    error_sum = acc;
    corr = longint'(gain_p) * err + longint'(gain_i) * acc
         + longint'(gain_d) * (err - last_err);
    corr = corr >>> lfps_pkg::FRAC_W;
    last_err = err;
    res.left  = clamp_duty(longint'(base_duty) - corr);
    res.right = clamp_duty(longint'(base_duty) + corr);
    res.err   = err[lfps_pkg::ERR_W-1:0];
    res.lost  = lost;
    pending_duties.push_back(res);
    samples_seen++;
    if (lost)
      lost_seen++;
  endfunction

  function void compare_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_duties(logic [47:0] data, logic user);
    duty_result_t want;
    if (pending_duties.size() == 0) begin
      mismatches++;
      $display("%0t ns: result beat with no sample outstanding, expected none, got %h",
               $time, data);
      return;
    end
    want = pending_duties.pop_front();
    results_checked++;
    compare_field("left_duty", want.left, data[14:0]);
    compare_field("right_duty", want.right, data[29:15]);
    compare_field("error_value", want.err, $signed(data[43:30]));
    compare_field("line_lost", want.lost, user);
  endfunction
endclass

module line_follow_pid_steering_test;
  localparam int MAX_WAIT       = 17;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int SW             = lfps_pkg::SENSOR_W;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = lfps_pkg::REG_GAIN_P;
  logic [23:0] cfg_data = '0;

  steering_checker board = new();
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int idle_cycles = 0;
  int settings_applied = 0;

  line_follow_pid_steering u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, board.pending_duties.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [4:0][SW-1:0] sensors(int a, int b, int c, int d, int e);
    return {e[9:0], d[9:0], c[9:0], b[9:0], a[9:0]};
  endfunction

  function automatic logic [4:0][SW-1:0] pick_sample(logic [SW-1:0] thr);
    logic [4:0][SW-1:0] rd;
    int kind, spot, lit;
    kind = $urandom_range(0, 99);
    spot = $urandom_range(0, 4);
    lit  = (thr == 10'd1023) ? 1023 : int'(thr) + 1;
    for (int k = 0; k < 5; k++)
      rd[k] = SW'($urandom_range(0, 1023));
    if (kind < 45) begin
      // line under one sensor, sometimes straddling its right neighbor
      for (int k = 0; k < 5; k++)
        rd[k] = SW'($urandom_range(0, thr));
      rd[spot] = SW'($urandom_range(lit, 1023));
      if (kind < 20 && spot < 4)
        rd[spot+1] = SW'($urandom_range(lit, 1023));
    end else if (kind < 60) begin
      for (int k = 0; k < 5; k++)
        rd[k] = SW'($urandom_range(0, thr));
    end else if (kind < 75) begin
      for (int k = 0; k < 5; k++)
        case ($urandom_range(0, 3))
          0:       rd[k] = '0;
          1:       rd[k] = '1;
          2:       rd[k] = thr;
          default: rd[k] = SW'(lit);
        endcase
    end
    return rd;
  endfunction

  task automatic send_sample(logic [4:0][SW-1:0] rd, bit drain_first);
    int gap;
    if ($urandom_range(0, 24) == 0)
      calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, MAX_WAIT);
    // force a nonzero gap when valid must drop, so that it really goes low
    if (drain_first && gap == 0)
      gap = 1;
    if (gap > 0)
      in_tvalid <= 1'b0;
    if (drain_first)
      while (board.pending_duties.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, rd};
    do @(posedge clk); while (!in_tready);
    board.predict_from_sample(rd);
  endtask

  task automatic finish_burst();
    in_tvalid <= 1'b0;
    while (board.pending_duties.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(int gp, int gi, int gd, int thr, int base, int lo, int hi,
                              int lim);
    int                 value [8];
    lfps_pkg::cfg_reg_t idx;
    value = '{gp, gi, gd, thr, base, lo, hi, lim};
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= 24'(value[idx]);
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(idx, 24'(value[idx]));
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic program_random();
    int gain [3];
    int thr, lo, hi;
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 3))
        0:       gain[k] = $urandom_range(0, 24'hFFFFFF);
        1:       gain[k] = $urandom_range(0, 1 << 12);
        default: gain[k] = $urandom_range(0, 1 << 16);
      endcase
    thr = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 1000);
    lo  = $urandom_range(0, 12800);
    hi  = $urandom_range(lo, 25600);
    program_regs(gain[0], gain[1], gain[2], thr, $urandom_range(0, 25600), lo, hi,
                 $urandom_range(0, 8191));
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++)
      send_sample(pick_sample(board.dark_level), $urandom_range(0, 39) == 0);
  endtask

  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 24) == 0)
        calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_duties(out_tdata, out_tuser);
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero sum, threshold edges, lost on either side, truncation both ways
    send_sample(sensors(0, 0, 0, 0, 0), 1'b0);
    send_sample(sensors(1000, 1000, 1000, 1000, 1000), 1'b0);
    send_sample(sensors(1023, 0, 0, 0, 0), 1'b0);
    send_sample(sensors(500, 500, 500, 500, 500), 1'b0);
    send_sample(sensors(501, 501, 501, 501, 501), 1'b0);
    send_sample(sensors(0, 0, 0, 0, 1023), 1'b0);
    send_sample(sensors(0, 0, 0, 0, 0), 1'b0);
    send_sample(sensors(0, 0, 1023, 0, 0), 1'b0);
    send_sample(sensors(0, 1023, 0, 0, 0), 1'b0);
    send_sample(sensors(0, 0, 0, 700, 3), 1'b0);
    send_sample(sensors(501, 0, 2, 0, 0), 1'b0);
    send_sample(sensors(1023, 1023, 1023, 1023, 1023), 1'b0);
    // drive the integral into both rails
    repeat (4) send_sample(sensors(1023, 0, 0, 0, 0), 1'b0);
    repeat (4) send_sample(sensors(0, 0, 0, 0, 1023), 1'b0);
    send_sample(sensors(0, 0, 0, 0, 0), 1'b0);
    send_sample(sensors(1023, 0, 0, 0, 1023), 1'b0);
    send_sample(sensors(1023, 1023, 0, 0, 0), 1'b0);
    finish_burst();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       program_regs(0, 0, 0, 0, 0, 0, 0, 0);
        1:       program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1000, 32767, 0, 32767, 8191);
        2:       program_regs($urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                              $urandom_range(0, 1 << 16), 0, 12800, 25600, 0, 4096);
        default: program_random();
      endcase
      run_random(phase < 3 ? 50 : 75);
      finish_burst();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d sensor samples (%0d with the line lost) over %0d register settings,",
             board.samples_seen, board.lost_seen, settings_applied + 1);
    $display("comparing %0d result beats with %0d mismatches.", board.results_checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
